FILE: hw/rtl/deq_pkg.sv
// Package for the double-ended queue: operation codes, status codes,
// controller states and the command that the controller sends to every cell.
// Depends on nothing.
`default_nettype none

package deq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [3:0] {
        OP_PUSH_FRONT   = 4'd0,
        OP_PUSH_BACK    = 4'd1,
        OP_POP_FRONT    = 4'd2,
        OP_POP_BACK     = 4'd3,
        OP_READ_FRONT   = 4'd4,
        OP_READ_BACK    = 4'd5,
        OP_SECOND_FRONT = 4'd6,
        OP_SECOND_BACK  = 4'd7,
        OP_LIST_ALL     = 4'd8
    } deq_op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } deq_state_t;

    // What every cell does at each clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,    // take the word from the front-side neighbour
        CELL_SHIFT_OUT,   // take the word from the back-side neighbour
        CELL_ROTATE,      // as SHIFT_OUT, but the tail cell takes the head word
        CELL_WRITE_TAIL   // the first free cell takes the pushed word
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] data;
    } deq_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue: controller and a chain of
// DEPTH cells. Depends on deq_pkg and deq_cell.
`default_nettype none

// Usage
// An item (operation, value) is transferred at a rising edge where start is
// high and busy is low. Results appear on word, status, occupancy and last
// for exactly one cycle, marked by done; the receiver takes every result in
// that cycle and cannot hold it off.
// The words sit in a row of cells with the front word always in cell 0.
// Pushing at the front shifts the whole row one place back, popping the
// front shifts it one place forward, and a push at the back writes the
// first free cell. Back-end reads are taken from the cell that recognises
// itself as the tail.
// Every operation except list-all gives its single result in the cycle after
// its transfer, and while busy is low a new item can be transferred every
// cycle. List-all on a non-empty queue holds busy high until every held word
// is out: each cycle the head word is sent out and the occupied part of the
// row rotates by one place, so after the last result the row is back in its
// original order. List-all on an empty queue gives one result at once.
// Reset empties the queue and clears the controller; cell contents are not
// reset, which is harmless as only pushed words are ever read.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [3:0]                    operation,
    input  wire logic signed [WORD_W-1:0]      value,
    output logic                               done,
    output logic signed [WORD_W-1:0]           word,
    output logic [1:0]                         status,
    output logic [$clog2(DEPTH+1)-1:0]         occupancy,
    output logic                               last
);

    localparam int CW = $clog2(DEPTH+1);

    deq_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     list_idx_reg, list_idx_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [1:0]        status_reg, status_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic              last_reg, last_next;

    deq_ctl_t          ctl;
    logic              accept;
    logic              full;
    logic              empty;
    logic              has_two;

    logic [WORD_W-1:0] cell_word  [DEPTH];
    logic [WORD_W-1:0] cell_tail  [DEPTH];
    logic [WORD_W-1:0] cell_tail2 [DEPTH];
    logic [WORD_W-1:0] back_word;
    logic [WORD_W-1:0] back2_word;

    // The cell chain. Cell 0 is the front; its front-side input is the pushed
    // word, and the last cell sees zero beyond the back.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] from_front;
        logic [WORD_W-1:0] from_back;

        if (i == 0)
        begin : g_first
            assign from_front = ctl.data;
        end
        else
        begin : g_mid
            assign from_front = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign from_back = '0;
        end
        else
        begin : g_inner
            assign from_back = cell_word[i+1];
        end

        deq_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .front_word (from_front),
            .back_word  (from_back),
            .head_word  (cell_word[0]),
            .word       (cell_word[i]),
            .tail_tap   (cell_tail[i]),
            .tail2_tap  (cell_tail2[i])
        );
    end

    // At most one cell raises each tap, so an OR gathers the back words.
    always_comb
    begin
        back_word  = '0;
        back2_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_word  = back_word  | cell_tail[i];
            back2_word = back2_word | cell_tail2[i];
        end
    end

    assign busy    = (state_reg == S_LIST);
    assign accept  = start && !busy;
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign has_two = (count_reg >= CW'(2));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        done_next     = 1'b0;
        word_next     = '0;
        status_next   = ST_OK;
        last_next     = 1'b1;
        ctl.op        = CELL_HOLD;
        ctl.data      = value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (deq_op_t'(operation))
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.op     = CELL_SHIFT_IN;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.op     = CELL_WRITE_TAIL;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                word_next  = cell_word[0];
                                ctl.op     = CELL_SHIFT_OUT;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                word_next  = back_word;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_READ_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                word_next = cell_word[0];
                            end
                        end
                        OP_READ_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                word_next = back_word;
                            end
                        end
                        OP_SECOND_FRONT:
                        begin
                            if (!has_two)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                word_next = cell_word[1];
                            end
                        end
                        OP_SECOND_BACK:
                        begin
                            if (!has_two)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                word_next = back2_word;
                            end
                        end
                        OP_LIST_ALL:
                        begin
                            if (empty)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                // The results come from the list state.
                                done_next     = 1'b0;
                                state_next    = S_LIST;
                                list_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                done_next = 1'b1;
                word_next = cell_word[0];
                ctl.op    = CELL_ROTATE;
                last_next = ((list_idx_reg + CW'(1)) == count_reg);
                if (last_next)
                begin
                    state_next    = S_IDLE;
                    list_idx_next = '0;
                end
                else
                begin
                    list_idx_next = list_idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        occ_next = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        status_reg <= status_next;
        occ_reg    <= occ_next;
        last_reg   <= last_next;
    end

    assign done      = done_reg;
    assign word      = word_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/deq_cell.sv
// One storage cell of the queue chain: holds one word and trades it with
// its neighbours as the controller commands. Depends on deq_pkg.
`default_nettype none

module deq_cell
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int INDEX = 0
)
(
    input  wire logic                         clk,
    input  wire deq_ctl_t                     ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   count,
    input  wire logic [WORD_W-1:0]            front_word,
    input  wire logic [WORD_W-1:0]            back_word,
    input  wire logic [WORD_W-1:0]            head_word,
    output logic      [WORD_W-1:0]            word,
    output logic      [WORD_W-1:0]            tail_tap,
    output logic      [WORD_W-1:0]            tail2_tap
);

    localparam int CW = $clog2(DEPTH+1);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              is_tail;
    logic              is_tail2;
    logic              is_free;

    assign is_tail  = (count == CW'(INDEX + 1));
    assign is_tail2 = (count == CW'(INDEX + 2));
    assign is_free  = (count == CW'(INDEX));

    always_comb
    begin
        word_next = word_reg;
        case (ctl.op)
            CELL_SHIFT_IN:   word_next = front_word;
            CELL_SHIFT_OUT:  word_next = back_word;
            CELL_ROTATE:     word_next = is_tail ? head_word : back_word;
            CELL_WRITE_TAIL:
            begin
                if (is_free)
                begin
                    word_next = ctl.data;
                end
            end
            default:         word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign tail_tap  = is_tail  ? word_reg : '0;
    assign tail2_tap = is_tail2 ? word_reg : '0;

endmodule

`default_nettype wire

FILE: dv/deq_monitor.sv
`timescale 1ns / 100ps
// Transfer monitor for the double-ended queue: keeps a shadow copy of the
// ring and compares every result transfer with the word, status, occupancy
// and last flag it should carry. Depends on deq_pkg.

module deq_monitor
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [3:0]                    operation,
    input  wire logic signed [WORD_W-1:0]      value,
    input  wire logic                          done,
    input  wire logic signed [WORD_W-1:0]      word,
    input  wire logic [1:0]                    status,
    input  wire logic [$clog2(DEPTH+1)-1:0]    occupancy,
    input  wire logic                          last,
    output int                                 pending,
    output int                                 mismatches
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } deq_result_t;

    logic signed [WORD_W-1:0] shadow_ring [DEPTH];
    int unsigned              shadow_head;
    int unsigned              shadow_count;
    deq_result_t              due_results [$];
    deq_result_t              oldest_due;

    function automatic int unsigned ring_slot(input int unsigned offset);
        return (shadow_head + offset) % DEPTH;
    endfunction

    // Queue up one result, tagged with the occupancy after the operation.
    function automatic void owe_result(input logic signed [WORD_W-1:0] w,
                                       input logic [1:0] st, input logic lst);
        deq_result_t r;
        r.word      = w;
        r.status    = st;
        r.occupancy = OCC_W'(shadow_count);
        r.last      = lst;
        due_results.push_back(r);
    endfunction

    function automatic void deque_apply(input logic [3:0] op,
                                        input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] w;
        logic [1:0]               st;
        int unsigned              i;
        w  = '0;
        st = ST_OK;
        case (op)
            OP_PUSH_FRONT:
                if (shadow_count == DEPTH)
                    st = ST_FULL;
                else
                begin
                    shadow_head = ring_slot(DEPTH - 1);
                    shadow_ring[shadow_head] = v;
                    shadow_count++;
                end
            OP_PUSH_BACK:
                if (shadow_count == DEPTH)
                    st = ST_FULL;
                else
                begin
                    shadow_ring[ring_slot(shadow_count)] = v;
                    shadow_count++;
                end
            OP_POP_FRONT:
                if (shadow_count == 0)
                    st = ST_MISSING;
                else
                begin
                    w = shadow_ring[shadow_head];
                    shadow_head = ring_slot(1);
                    shadow_count--;
                end
            OP_POP_BACK:
                if (shadow_count == 0)
                    st = ST_MISSING;
                else
                begin
                    w = shadow_ring[ring_slot(shadow_count - 1)];
                    shadow_count--;
                end
            OP_READ_FRONT:
                if (shadow_count == 0)
                    st = ST_MISSING;
                else
                    w = shadow_ring[shadow_head];
            OP_READ_BACK:
                if (shadow_count == 0)
                    st = ST_MISSING;
                else
                    w = shadow_ring[ring_slot(shadow_count - 1)];
            OP_SECOND_FRONT:
                if (shadow_count < 2)
                    st = ST_MISSING;
                else
                    w = shadow_ring[ring_slot(1)];
            OP_SECOND_BACK:
                if (shadow_count < 2)
                    st = ST_MISSING;
                else
                    w = shadow_ring[ring_slot(shadow_count - 2)];
            OP_LIST_ALL:
                if (shadow_count == 0)
                    st = ST_MISSING;
                else
                begin
                    for (i = 0; i < shadow_count; i++)
                        owe_result(shadow_ring[ring_slot(i)], ST_OK,
                                   (i + 1 == shadow_count));
                    return;
                end
            default:
                ;
        endcase
        owe_result(w, st, 1'b1);
    endfunction

    // Results are compared before the transfer of the same edge is applied,
    // so a stray result can never be paired with a newly accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_head  = 0;
            shadow_count = 0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: word %0d", word);
                    mismatches++;
                end
                else
                begin
                    oldest_due = due_results.pop_front();
                    if (word !== oldest_due.word)
                    begin
                        $error("word: expected %0d, got %0d", oldest_due.word, word);
                        mismatches++;
                    end
                    if (status !== oldest_due.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest_due.status, status);
                        mismatches++;
                    end
                    if (occupancy !== oldest_due.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               oldest_due.occupancy, occupancy);
                        mismatches++;
                    end
                    if (last !== oldest_due.last)
                    begin
                        $error("last: expected %0d, got %0d", oldest_due.last, last);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                deque_apply(operation, value);
            pending <= due_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the double-ended queue testbench: clock, reset and command stimulus,
// with the block and deq_monitor side by side. Depends on deq_pkg,
// double_ended_queue and deq_monitor.

module testbench;
    import deq_pkg::*;

    localparam int DEPTH = 16;
    localparam int OCC_W = $clog2(DEPTH + 1);

    // Codes beyond the defined operations; the block must answer them with
    // a single plain result and leave the contents alone.
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [3:0]               operation;
    logic signed [WORD_W-1:0] value;
    logic                     busy;
    logic                     done;
    logic signed [WORD_W-1:0] word;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
    int                       pending;
    int                       mismatches;

    // Chance, in percent, that the sender leaves a cycle empty before an item.
    int                       idle_pct;

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .value     (value),
        .done      (done),
        .word      (word),
        .status    (status),
        .occupancy (occupancy),
        .last      (last)
    );

    deq_monitor #(
        .DEPTH (DEPTH)
    ) monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .value      (value),
        .done       (done),
        .word       (word),
        .status     (status),
        .occupancy  (occupancy),
        .last       (last),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // An empty cycle on the command side. The operation and value lines are
    // filled with rubbish meanwhile, which the block must not act upon.
    task automatic idle_cycle();
        start     <= 1'b0;
        operation <= 4'($urandom);
        value     <= $urandom;
        @(posedge clk);
    endtask

    // Presents one item and returns at the edge where its transfer happens.
    // busy is read just after the edge, so it still holds the value that
    // decided the transfer. Since start is left high on return, the next
    // item can follow in the very next cycle.
    task automatic issue(input logic [3:0] op, input logic signed [WORD_W-1:0] v);
        while ($urandom_range(99) < idle_pct)
            idle_cycle();
        start     <= 1'b1;
        operation <= op;
        value     <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Holds the sender off until every owed result has come out. It must be
    // entered at the edge of a transfer, so that the first look at pending
    // comes at the following edge and already counts that transfer.
    task automatic drain_outstanding();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Words to push: the extremes and the all-zero and all-one patterns turn
    // up often, ordinary random words the rest of the time.
    function automatic logic signed [WORD_W-1:0] pick_value();
        logic signed [WORD_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = '0;
            3:       v = '1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] any_push();
        return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [3:0] any_pop();
        return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // Operations that leave the contents as they are.
    function automatic logic [3:0] any_query();
        logic [3:0] op;
        case ($urandom_range(5))
            0:       op = OP_READ_FRONT;
            1:       op = OP_READ_BACK;
            2:       op = OP_SECOND_FRONT;
            3:       op = OP_SECOND_BACK;
            4:       op = OP_LIST_ALL;
            default: op = 4'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
        endcase
        return op;
    endfunction

    // One round of random traffic, starting from an empty queue. It pushes
    // fill words (past capacity when fill exceeds DEPTH, so that a push is
    // refused), lists the queue, mixes in a few arbitrary codes, then pops
    // enough times to empty it even if those codes pushed, so that at least
    // one pop finds nothing. Queries are scattered throughout so the read
    // paths see every fill level. The round closes by waiting for the queue
    // to finish talking.
    task automatic run_round(input int pct, input int fill);
        idle_pct = pct;
        repeat (fill)
        begin
            if ($urandom_range(4) == 0)
                issue(any_query(), $urandom);
            issue(any_push(), pick_value());
        end
        issue(OP_LIST_ALL, $urandom);
        repeat (3)
            issue(4'($urandom_range(15)), pick_value());
        repeat (fill + 4)
        begin
            if ($urandom_range(4) == 0)
                issue(any_query(), $urandom);
            issue(any_pop(), $urandom);
        end
        drain_outstanding();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_PUSH_FRONT;
        value     = '0;
        idle_pct  = 37;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: every request on an empty queue must be
        // reported as missing, including list-all and both second-word
        // reads; unknown codes are answered plainly.
        issue(OP_READ_FRONT, '0);
        issue(OP_READ_BACK, '1);
        issue(OP_POP_FRONT, '0);
        issue(OP_POP_BACK, '1);
        issue(OP_SECOND_FRONT, '0);
        issue(OP_SECOND_BACK, '1);
        issue(OP_LIST_ALL, '0);
        issue(OP_UNKNOWN_HI, '1);
        // With a single word held, the second-word reads still come up empty.
        issue(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        issue(OP_SECOND_FRONT, '0);
        issue(OP_SECOND_BACK, '0);
        // All-zero and all-one words at the ends, then every read and a full listing.
        issue(OP_PUSH_BACK, 32'sh8000_0000);
        issue(OP_PUSH_FRONT, '0);
        issue(OP_PUSH_BACK, '1);
        issue(OP_READ_FRONT, '0);
        issue(OP_READ_BACK, '0);
        issue(OP_SECOND_FRONT, '0);
        issue(OP_SECOND_BACK, '0);
        issue(OP_LIST_ALL, '1);
        issue(OP_UNKNOWN_LO, 32'sh7FFF_FFFF);
        issue(OP_POP_FRONT, '0);
        issue(OP_POP_BACK, '0);
        issue(OP_POP_FRONT, '0);
        issue(OP_POP_BACK, '0);
        // The sender stands back here until every result is in.
        drain_outstanding();

        // Random rounds: sparse gaps with the queue overfilled, then
        // frequent gaps, then none at all, both at a quarter of capacity.
        run_round(37, DEPTH + 1);
        run_round(77, DEPTH / 4);
        run_round(0, DEPTH / 4);

        // A few quiet cycles so that any stray result still shows up.
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every list-all
    // at full depth.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/double_ended_queue.sv
dv/deq_monitor.sv
dv/testbench.sv
